>>> sv/vicsd_pkg.sv
// Shared types, constants and helper functions for the vector icon stream decoder.
// Depends on nothing; every other file of the decoder imports it.

package vicsd_pkg;

	// Depth of the command queue between the parser and the record builder.
	localparam int VICSD_QDEPTH = 4;

	// Reset value of the alpha threshold register.
	localparam logic [15:0] ALPHA_THR_RESET = 16'd65;

	// Number of bytes buffered for a path header before its last byte.
	localparam int FIELD_DEPTH = 19;

	// Byte positions inside a file header, a path header and a point.
	localparam logic [4:0] POS_MAGIC_LAST = 5'd3;
	localparam logic [4:0] POS_COUNT_LO   = 5'd4;
	localparam logic [4:0] POS_COUNT_HI   = 5'd5;
	localparam logic [4:0] POS_HDR_LAST   = 5'd19;
	localparam logic [4:0] POS_PT_LAST    = 5'd3;

	// Expected file magic, first byte first.
	localparam logic [7:0] MAGIC_B0 = 8'h54;
	localparam logic [7:0] MAGIC_B1 = 8'h54;
	localparam logic [7:0] MAGIC_B2 = 8'h49;
	localparam logic [7:0] MAGIC_B3 = 8'h43;

	// Record kinds on the output.
	typedef enum logic [2:0] {
		KIND_PATH    = 3'd0,
		KIND_CONTOUR = 3'd1,
		KIND_POINT   = 3'd2,
		KIND_END     = 3'd3,
		KIND_BAD     = 3'd4
	} rec_kind_t;

	// Parser phases.
	typedef enum logic [4:0] {
		PH_FILE    = 5'b00001,
		PH_PATH    = 5'b00010,
		PH_CONTOUR = 5'b00100,
		PH_POINT   = 5'b01000,
		PH_IDLE    = 5'b10000
	} phase_t;

	// Point type codes.
	localparam logic [1:0] PT_ANCHOR = 2'd0;
	localparam logic [1:0] PT_QUAD   = 2'd1;
	localparam logic [1:0] PT_CUBIC1 = 2'd2;
	localparam logic [1:0] PT_CUBIC2 = 2'd3;

	// One queued command: the raw fields of one record, plus a flag that
	// asks the back end to follow it with an icon-end record.
	typedef struct packed {
		rec_kind_t   kind;
		logic [63:0] fill_raw;
		logic [63:0] stroke_raw;
		logic [15:0] width_raw;
		logic [15:0] count;
		logic [15:0] x_raw;
		logic [15:0] y_raw;
		logic        end_after;
	} cmd_t;

	// Expected magic byte at a given position.
	function automatic logic [7:0] magic_byte(input logic [1:0] idx);
		logic [7:0] m;
		case (idx)
			2'd0:    m = MAGIC_B0;
			2'd1:    m = MAGIC_B1;
			2'd2:    m = MAGIC_B2;
			default: m = MAGIC_B3;
		endcase
		return m;
	endfunction

	// Point type from the flag bits of x and y.
	function automatic logic [1:0] point_type_map(input logic fx, input logic fy);
		logic [1:0] t;
		case ({fy, fx})
			2'b00:   t = PT_ANCHOR;
			2'b01:   t = PT_CUBIC1;
			2'b10:   t = PT_CUBIC2;
			default: t = PT_QUAD;
		endcase
		return t;
	endfunction

endpackage

>>> sv/vicsd_front.sv
// Byte parser: tracks the file structure, assembles fields and queues commands.
// Depends on vicsd_pkg.

module vicsd_front
	import vicsd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       byte_valid,
	input  logic       byte_ready,
	input  logic [7:0] data_byte,
	input  logic       frame_start,
	output logic       push,
	output cmd_t       push_cmd
);

	phase_t      phase_q;
	logic [4:0]  pos_q;
	logic        magic_good_q;
	logic [15:0] paths_q;
	logic [15:0] contours_q;
	logic [15:0] points_q;
	logic [7:0]  field_q [FIELD_DEPTH];

	phase_t      ph_e;
	logic [4:0]  pos_e;
	logic        mg_e;
	logic [15:0] paths_e;
	logic [15:0] contours_e;
	logic [15:0] points_e;

	phase_t      ph_n;
	logic [4:0]  pos_n;
	logic        mg_n;
	logic [15:0] paths_n;
	logic [15:0] contours_n;
	logic [15:0] points_n;
	logic        fb_we;
	logic [4:0]  fb_addr;
	logic [15:0] cnt_new;
	logic        emit;
	logic        accept;

	assign accept = byte_valid & byte_ready;

	// A frame start restarts the parser before this byte is looked at.
	always_comb begin
		ph_e       = frame_start ? PH_FILE : phase_q;
		pos_e      = frame_start ? 5'd0 : pos_q;
		mg_e       = frame_start ? 1'b1 : magic_good_q;
		paths_e    = frame_start ? 16'd0 : paths_q;
		contours_e = frame_start ? 16'd0 : contours_q;
		points_e   = frame_start ? 16'd0 : points_q;
	end

	// Next state and command for the current byte.
	always_comb begin
		ph_n       = ph_e;
		pos_n      = pos_e;
		mg_n       = mg_e;
		paths_n    = paths_e;
		contours_n = contours_e;
		points_n   = points_e;
		fb_we      = 1'b0;
		fb_addr    = pos_e;
		emit       = 1'b0;
		cnt_new    = 16'd0;
		push_cmd   = '0;
		push_cmd.kind = KIND_PATH;

		case (ph_e)
			PH_FILE: begin
				if (pos_e < 5'd4) begin
					mg_n = mg_e & (data_byte == magic_byte(pos_e[1:0]));
					if (pos_e == POS_MAGIC_LAST && !mg_n) begin
						emit          = 1'b1;
						push_cmd.kind = KIND_BAD;
						ph_n          = PH_IDLE;
						pos_n         = 5'd0;
					end else begin
						pos_n = 5'(pos_e + 5'd1);
					end
				end else if (pos_e == POS_COUNT_LO) begin
					// The low byte of the path count is held in the first field slot.
					fb_we   = 1'b1;
					fb_addr = 5'd0;
					pos_n   = POS_COUNT_HI;
				end else begin
					paths_n = {data_byte, field_q[0]};
					pos_n   = 5'd0;
					if (paths_n == 16'd0) begin
						emit          = 1'b1;
						push_cmd.kind = KIND_END;
						ph_n          = PH_IDLE;
					end else begin
						ph_n = PH_PATH;
					end
				end
			end
			PH_PATH: begin
				if (pos_e < POS_HDR_LAST) begin
					fb_we = 1'b1;
					pos_n = 5'(pos_e + 5'd1);
				end else begin
					cnt_new    = {data_byte, field_q[18]};
					contours_n = cnt_new;
					pos_n      = 5'd0;
					emit       = 1'b1;
					push_cmd.kind = KIND_PATH;
					for (int i = 0; i < 8; i++) begin
						push_cmd.fill_raw[8*i +: 8]   = field_q[i];
						push_cmd.stroke_raw[8*i +: 8] = field_q[8+i];
					end
					push_cmd.width_raw = {field_q[17], field_q[16]};
					push_cmd.count     = cnt_new;
					if (cnt_new == 16'd0) begin
						paths_n = 16'(paths_e - 16'd1);
						if (paths_n == 16'd0) begin
							push_cmd.end_after = 1'b1;
							ph_n = PH_IDLE;
						end else begin
							ph_n = PH_PATH;
						end
					end else begin
						ph_n = PH_CONTOUR;
					end
				end
			end
			PH_CONTOUR: begin
				if (pos_e == 5'd0) begin
					fb_we = 1'b1;
					pos_n = 5'd1;
				end else begin
					cnt_new  = {data_byte, field_q[0]};
					points_n = cnt_new;
					pos_n    = 5'd0;
					emit     = 1'b1;
					push_cmd.kind  = KIND_CONTOUR;
					push_cmd.count = cnt_new;
					if (cnt_new == 16'd0) begin
						contours_n = 16'(contours_e - 16'd1);
						if (contours_n == 16'd0) begin
							paths_n = 16'(paths_e - 16'd1);
							if (paths_n == 16'd0) begin
								push_cmd.end_after = 1'b1;
								ph_n = PH_IDLE;
							end else begin
								ph_n = PH_PATH;
							end
						end else begin
							ph_n = PH_CONTOUR;
						end
					end else begin
						ph_n = PH_POINT;
					end
				end
			end
			PH_POINT: begin
				if (pos_e < POS_PT_LAST) begin
					fb_we = 1'b1;
					pos_n = 5'(pos_e + 5'd1);
				end else begin
					pos_n = 5'd0;
					emit  = 1'b1;
					push_cmd.kind  = KIND_POINT;
					push_cmd.x_raw = {field_q[1], field_q[0]};
					push_cmd.y_raw = {data_byte, field_q[2]};
					points_n = 16'(points_e - 16'd1);
					if (points_n == 16'd0) begin
						contours_n = 16'(contours_e - 16'd1);
						if (contours_n == 16'd0) begin
							paths_n = 16'(paths_e - 16'd1);
							if (paths_n == 16'd0) begin
								push_cmd.end_after = 1'b1;
								ph_n = PH_IDLE;
							end else begin
								ph_n = PH_PATH;
							end
						end else begin
							ph_n = PH_CONTOUR;
						end
					end
				end
			end
			default: begin
				ph_n  = PH_IDLE;
				pos_n = 5'd0;
			end
		endcase
	end

	assign push = accept & emit;

	// Parser state advances on every byte transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_FILE;
			pos_q        <= 5'd0;
			magic_good_q <= 1'b1;
			paths_q      <= 16'd0;
			contours_q   <= 16'd0;
			points_q     <= 16'd0;
		end else if (accept) begin
			phase_q      <= ph_n;
			pos_q        <= pos_n;
			magic_good_q <= mg_n;
			paths_q      <= paths_n;
			contours_q   <= contours_n;
			points_q     <= points_n;
		end
	end

	// Field byte buffer, written at the slot chosen for the current byte.
	always_ff @(posedge clk) begin
		if (accept && fb_we) begin
			field_q[fb_addr] <= data_byte;
		end
	end

endmodule

>>> sv/vicsd_fifo.sv
// Short command queue between the parser and the record builder.
// Depends on vicsd_pkg for the command type.

module vicsd_fifo
	import vicsd_pkg::*;
#(
	parameter int QDEPTH = VICSD_QDEPTH
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	output logic full,
	input  logic pop,
	output logic not_empty,
	output cmd_t head_cmd
);

	localparam int AW = $clog2(QDEPTH);
	localparam int CW = $clog2(QDEPTH + 1);

	cmd_t          slot_q [QDEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	assign full      = (count_q == CW'(QDEPTH));
	assign not_empty = (count_q != '0);
	assign head_cmd  = slot_q[rd_ptr_q];

	// Pointers wrap at the queue depth.
	function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
		logic [AW-1:0] r;
		if (p == AW'(QDEPTH - 1)) begin
			r = '0;
		end else begin
			r = AW'(p + 1'b1);
		end
		return r;
	endfunction

	// Occupancy and pointer update.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= CW'(count_q + 1'b1);
			end else if (pop && !push) begin
				count_q <= CW'(count_q - 1'b1);
			end
		end
	end

	// Command storage.
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

>>> sv/vicsd_back.sv
// Record builder: expands queued commands into output records in an output register.
// Depends on vicsd_pkg.

module vicsd_back
	import vicsd_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic [15:0]        alpha_threshold,
	input  logic               cmd_avail,
	input  cmd_t               cmd,
	output logic               pop,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [2:0]         rec_kind,
	output logic [63:0]        fill_rgba,
	output logic [63:0]        stroke_rgba,
	output logic signed [14:0] line_width,
	output logic               join_bevel,
	output logic               fill_on,
	output logic               stroke_on,
	output logic [15:0]        item_count,
	output logic signed [14:0] point_x,
	output logic signed [14:0] point_y,
	output logic [1:0]         point_type,
	output logic               run_last
);

	logic        valid_q;
	logic        end_pend_q;
	rec_kind_t   kind_q;
	logic [63:0] fill_q;
	logic [63:0] stroke_q;
	logic [14:0] width_q;
	logic        bevel_q;
	logic        fill_on_q;
	logic        stroke_on_q;
	logic [15:0] count_q;
	logic [14:0] x_q;
	logic [14:0] y_q;
	logic [1:0]  type_q;
	logic        last_q;
	logic        slot_free;
	logic        load_end;

	// The output register takes a new record when empty or when its record transfers.
	assign slot_free = !valid_q || out_ready;
	assign load_end  = slot_free && end_pend_q;
	assign pop       = slot_free && !end_pend_q && cmd_avail;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= 1'b0;
			end_pend_q <= 1'b0;
		end else if (slot_free) begin
			valid_q <= load_end || pop;
			if (load_end) begin
				end_pend_q <= 1'b0;
			end else if (pop) begin
				end_pend_q <= cmd.end_after;
			end
		end
	end

	// Record payload: an icon end after its companion, or the head command.
	always_ff @(posedge clk) begin
		if (load_end) begin
			kind_q      <= KIND_END;
			fill_q      <= '0;
			stroke_q    <= '0;
			width_q     <= '0;
			bevel_q     <= 1'b0;
			fill_on_q   <= 1'b0;
			stroke_on_q <= 1'b0;
			count_q     <= '0;
			x_q         <= '0;
			y_q         <= '0;
			type_q      <= PT_ANCHOR;
			last_q      <= 1'b1;
		end else if (pop) begin
			kind_q      <= cmd.kind;
			fill_q      <= cmd.fill_raw;
			stroke_q    <= cmd.stroke_raw;
			width_q     <= cmd.width_raw[15:1];
			bevel_q     <= cmd.width_raw[0];
			fill_on_q   <= cmd.fill_raw[63:48] > alpha_threshold;
			stroke_on_q <= cmd.stroke_raw[63:48] > alpha_threshold;
			count_q     <= cmd.count;
			x_q         <= cmd.x_raw[15:1];
			y_q         <= cmd.y_raw[15:1];
			type_q      <= point_type_map(cmd.x_raw[0], cmd.y_raw[0]);
			last_q      <= !cmd.end_after;
		end
	end

	assign out_valid   = valid_q;
	assign rec_kind    = kind_q;
	assign fill_rgba   = fill_q;
	assign stroke_rgba = stroke_q;
	assign line_width  = width_q;
	assign join_bevel  = bevel_q;
	assign fill_on     = fill_on_q;
	assign stroke_on   = stroke_on_q;
	assign item_count  = count_q;
	assign point_x     = x_q;
	assign point_y     = y_q;
	assign point_type  = type_q;
	assign run_last    = last_q;

endmodule

>>> sv/vector_icon_stream_decoder_unit.sv
// Vector icon stream decoder: one file byte per transfer in, decoded records out.
// Throughput: one byte per cycle; a byte that yields two records holds the output for both in turn,
// and bytes stall only while the four-entry command queue is full.
// Path: the byte's transfer edge writes the command queue, and a later pop, once the output register
// is free, loads the record builder's output register, which then presents the record.
// Reset: asynchronous, active low; the parser expects a magic byte next, the threshold is 65.

module vector_icon_stream_decoder_unit
	import vicsd_pkg::*;
#(
	parameter int QDEPTH = VICSD_QDEPTH
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [7:0]         data_byte,
	input  logic               frame_start,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [15:0]        cfg_data,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [2:0]         rec_kind,
	output logic [63:0]        fill_rgba,
	output logic [63:0]        stroke_rgba,
	output logic signed [14:0] line_width,
	output logic               join_bevel,
	output logic               fill_on,
	output logic               stroke_on,
	output logic [15:0]        item_count,
	output logic signed [14:0] point_x,
	output logic signed [14:0] point_y,
	output logic [1:0]         point_type,
	output logic               run_last
);

	logic [15:0] alpha_thr_q;
	logic        q_full;
	logic        q_push;
	cmd_t        q_push_cmd;
	logic        q_pop;
	logic        q_avail;
	cmd_t        q_head;

	// Alpha threshold register, written by a configuration transfer.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_thr_q <= ALPHA_THR_RESET;
		end else if (cfg_valid && cfg_ready) begin
			alpha_thr_q <= cfg_data;
		end
	end

	// Bytes are taken while the command queue has room.
	assign in_ready = !q_full;

	vicsd_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.byte_valid  (in_valid),
		.byte_ready  (in_ready),
		.data_byte   (data_byte),
		.frame_start (frame_start),
		.push        (q_push),
		.push_cmd    (q_push_cmd)
	);

	vicsd_fifo #(
		.QDEPTH (QDEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_cmd  (q_push_cmd),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_avail),
		.head_cmd  (q_head)
	);

	vicsd_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.alpha_threshold (alpha_thr_q),
		.cmd_avail       (q_avail),
		.cmd             (q_head),
		.pop             (q_pop),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.rec_kind        (rec_kind),
		.fill_rgba       (fill_rgba),
		.stroke_rgba     (stroke_rgba),
		.line_width      (line_width),
		.join_bevel      (join_bevel),
		.fill_on         (fill_on),
		.stroke_on       (stroke_on),
		.item_count      (item_count),
		.point_x         (point_x),
		.point_y         (point_y),
		.point_type      (point_type),
		.run_last        (run_last)
	);

endmodule

>>> verif/vector_icon_stream_decoder_unit_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for vector_icon_stream_decoder_unit: feeds icon byte streams and
// compares every decoded record against an in-bench parse of the same bytes.
// Depends on vicsd_pkg and the decoder RTL.

module vector_icon_stream_decoder_unit_tb;
	import vicsd_pkg::*;

	localparam int unsigned RUN_LIMIT    = 200000;
	localparam int          SETTLE       = 8;
	localparam int          RANDOM_BYTES = 660;

	// Magic bytes, first byte in the low bits.
	localparam logic [31:0] ICON_MAGIC = {MAGIC_B3, MAGIC_B2, MAGIC_B1, MAGIC_B0};

	// One decoded record as it appears on the output ports.
	typedef struct {
		rec_kind_t          kind;
		logic [63:0]        fill;
		logic [63:0]        stroke;
		logic signed [14:0] width;
		logic               bevel;
		logic               fill_en;
		logic               stroke_en;
		logic [15:0]        count;
		logic signed [14:0] x;
		logic signed [14:0] y;
		logic [1:0]         ptype;
		logic               last;
	} icon_rec_t;

	// Tracks the parse of the byte stream and holds the records still due from the decoder.
	class icon_parse_tracker;
		logic [15:0] alpha_thr;
		phase_t      phase;
		logic [4:0]  pos;
		logic [7:0]  held [FIELD_DEPTH];
		logic        magic_ok;
		logic [15:0] paths_left;
		logic [15:0] contours_left;
		logic [15:0] points_left;
		icon_rec_t   due_records [$];
		int unsigned errors;

		function new();
			alpha_thr = ALPHA_THR_RESET;
			phase = PH_FILE;
			pos = '0;
			magic_ok = 1'b1;
			paths_left = '0;
			contours_left = '0;
			points_left = '0;
			errors = 0;
		endfunction

		function icon_rec_t blank(rec_kind_t k);
			icon_rec_t r;
			r.kind = k;
			r.fill = '0;
			r.stroke = '0;
			r.width = '0;
			r.bevel = 1'b0;
			r.fill_en = 1'b0;
			r.stroke_en = 1'b0;
			r.count = '0;
			r.x = '0;
			r.y = '0;
			r.ptype = PT_ANCHOR;
			r.last = 1'b0;
			return r;
		endfunction

		// Append a record to the tail of the due list.
		function void add_due(icon_rec_t r);
			due_records.insert(due_records.size(), r);
		endfunction

		// A path is finished; the icon ends after the last one.
		function void path_closed();
			paths_left = paths_left - 16'd1;
			if (paths_left == 16'd0) begin
				add_due(blank(KIND_END));
				phase = PH_IDLE;
			end else begin
				phase = PH_PATH;
			end
		endfunction

		function void contour_closed();
			contours_left = contours_left - 16'd1;
			if (contours_left == 16'd0) begin
				path_closed();
			end else begin
				phase = PH_CONTOUR;
			end
		endfunction

		// Advance the parse by one accepted byte and queue the records it completes.
		function void take_byte(logic [7:0] b, logic fs);
			icon_rec_t   r;
			logic [15:0] sw;
			logic [15:0] xr;
			logic [15:0] yr;
			int          due_start;
			int          i;
			due_start = due_records.size();
			if (fs) begin
				phase = PH_FILE;
				pos = '0;
				magic_ok = 1'b1;
				paths_left = '0;
				contours_left = '0;
				points_left = '0;
			end
			case (phase)
				PH_FILE: begin
					if (pos < 5'd4) begin
						if (b != ICON_MAGIC[8 * pos[1:0] +: 8])
							magic_ok = 1'b0;
						if (pos == POS_MAGIC_LAST && !magic_ok) begin
							add_due(blank(KIND_BAD));
							phase = PH_IDLE;
							pos = '0;
						end else begin
							pos = pos + 5'd1;
						end
					end else if (pos == POS_COUNT_LO) begin
						held[0] = b;
						pos = POS_COUNT_HI;
					end else begin
						paths_left = {b, held[0]};
						pos = '0;
						if (paths_left == 16'd0) begin
							add_due(blank(KIND_END));
							phase = PH_IDLE;
						end else begin
							phase = PH_PATH;
						end
					end
				end
				PH_PATH: begin
					if (pos < POS_HDR_LAST) begin
						held[pos] = b;
						pos = pos + 5'd1;
					end else begin
						r = blank(KIND_PATH);
						for (i = 0; i < 8; i++) begin
							r.fill[8 * i +: 8] = held[i];
							r.stroke[8 * i +: 8] = held[8 + i];
						end
						sw = {held[17], held[16]};
						contours_left = {b, held[18]};
						pos = '0;
						r.width = sw[15:1];
						r.bevel = sw[0];
						r.fill_en = r.fill[63:48] > alpha_thr;
						r.stroke_en = r.stroke[63:48] > alpha_thr;
						r.count = contours_left;
						add_due(r);
						if (contours_left == 16'd0) begin
							path_closed();
						end else begin
							phase = PH_CONTOUR;
						end
					end
				end
				PH_CONTOUR: begin
					if (pos == 5'd0) begin
						held[0] = b;
						pos = 5'd1;
					end else begin
						points_left = {b, held[0]};
						pos = '0;
						r = blank(KIND_CONTOUR);
						r.count = points_left;
						add_due(r);
						if (points_left == 16'd0) begin
							contour_closed();
						end else begin
							phase = PH_POINT;
						end
					end
				end
				PH_POINT: begin
					if (pos < POS_PT_LAST) begin
						held[pos] = b;
						pos = pos + 5'd1;
					end else begin
						xr = {held[1], held[0]};
						yr = {b, held[2]};
						pos = '0;
						r = blank(KIND_POINT);
						r.x = xr[15:1];
						r.y = yr[15:1];
						// Flag bits: none is an anchor, both a quadratic control,
						// x alone the first cubic control, y alone the second.
						case ({yr[0], xr[0]})
							2'b00:   r.ptype = PT_ANCHOR;
							2'b11:   r.ptype = PT_QUAD;
							2'b01:   r.ptype = PT_CUBIC1;
							default: r.ptype = PT_CUBIC2;
						endcase
						add_due(r);
						points_left = points_left - 16'd1;
						if (points_left == 16'd0)
							contour_closed();
					end
				end
				default: begin
					phase = PH_IDLE;
					pos = '0;
				end
			endcase
			// The last record caused by this byte carries the run-last mark.
			if (due_records.size() > due_start) begin
				r = due_records.pop_back();
				r.last = 1'b1;
				add_due(r);
			end
		endfunction

		function void same(string name, logic [63:0] want, logic [63:0] got);
			if (want !== got) begin
				$error("%s mismatch: expected %0h, actual %0h", name, want, got);
				errors++;
			end
		endfunction

		// Compare one record from the decoder with the oldest one due.
		function void match_record(icon_rec_t got);
			icon_rec_t want;
			if (due_records.size() == 0) begin
				$error("record of kind %0d arrived with none due", got.kind);
				errors++;
				return;
			end
			want = due_records.pop_front();
			same("rec_kind", want.kind, got.kind);
			same("fill_rgba", want.fill, got.fill);
			same("stroke_rgba", want.stroke, got.stroke);
			same("line_width", want.width, got.width);
			same("join_bevel", want.bevel, got.bevel);
			same("fill_on", want.fill_en, got.fill_en);
			same("stroke_on", want.stroke_en, got.stroke_en);
			same("item_count", want.count, got.count);
			same("point_x", want.x, got.x);
			same("point_y", want.y, got.y);
			same("point_type", want.ptype, got.ptype);
			same("run_last", want.last, got.last);
		endfunction
	endclass

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic [7:0]         data_byte = '0;
	logic               frame_start = 1'b0;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic [15:0]        cfg_data = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic [2:0]         rec_kind;
	logic [63:0]        fill_rgba;
	logic [63:0]        stroke_rgba;
	logic signed [14:0] line_width;
	logic               join_bevel;
	logic               fill_on;
	logic               stroke_on;
	logic [15:0]        item_count;
	logic signed [14:0] point_x;
	logic signed [14:0] point_y;
	logic [1:0]         point_type;
	logic               run_last;

	icon_parse_tracker parse_track;
	int unsigned       cycle_count = 0;
	int unsigned       send_idle = 33;
	int unsigned       recv_idle = 70;
	int                sent_bytes = 0;
	logic [7:0]        frame_q [$];

	vector_icon_stream_decoder_unit DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.data_byte   (data_byte),
		.frame_start (frame_start),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_data    (cfg_data),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.rec_kind    (rec_kind),
		.fill_rgba   (fill_rgba),
		.stroke_rgba (stroke_rgba),
		.line_width  (line_width),
		.join_bevel  (join_bevel),
		.fill_on     (fill_on),
		.stroke_on   (stroke_on),
		.item_count  (item_count),
		.point_x     (point_x),
		.point_y     (point_y),
		.point_type  (point_type),
		.run_last    (run_last)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	// Watch every transfer on all three channels and drive the receiver's stalls.
	always @(posedge clk) begin : watch
		icon_rec_t seen;
		cycle_count <= cycle_count + 1;
		out_ready <= ($urandom_range(99) >= recv_idle);
		if (cfg_valid && cfg_ready)
			parse_track.alpha_thr = cfg_data;
		if (in_valid && in_ready)
			parse_track.take_byte(data_byte, frame_start);
		if (out_valid && out_ready) begin
			seen.kind = rec_kind_t'(rec_kind);
			seen.fill = fill_rgba;
			seen.stroke = stroke_rgba;
			seen.width = line_width;
			seen.bevel = join_bevel;
			seen.fill_en = fill_on;
			seen.stroke_en = stroke_on;
			seen.count = item_count;
			seen.x = point_x;
			seen.y = point_y;
			seen.ptype = point_type;
			seen.last = run_last;
			parse_track.match_record(seen);
		end
	end

	// Give up on a hung run.
	initial begin
		while (cycle_count < RUN_LIMIT)
			@(posedge clk);
		$display("Simulation FAILED");
		$finish;
	end

	// Stream building.
	function automatic void put_byte(logic [7:0] b);
		frame_q.insert(frame_q.size(), b);
	endfunction

	function automatic void put16(logic [15:0] v);
		put_byte(v[7:0]);
		put_byte(v[15:8]);
	endfunction

	function automatic void put_magic(bit corrupt);
		int k;
		for (k = 0; k < 4; k++)
			put_byte(ICON_MAGIC[8 * k +: 8]);
		if (corrupt) begin
			k = $urandom_range(3);
			frame_q[k] = frame_q[k] ^ 8'($urandom_range(1, 255));
		end
	endfunction

	function automatic void put_path_header(logic [63:0] fill, logic [63:0] stroke,
			logic [15:0] width, logic [15:0] ncont);
		put16(fill[15:0]);
		put16(fill[31:16]);
		put16(fill[47:32]);
		put16(fill[63:48]);
		put16(stroke[15:0]);
		put16(stroke[31:16]);
		put16(stroke[47:32]);
		put16(stroke[63:48]);
		put16(width);
		put16(ncont);
	endfunction

	// Alphas cluster around the threshold so both sides of the compare are hit.
	function automatic logic [15:0] pick_alpha();
		logic [15:0] thr;
		thr = parse_track.alpha_thr;
		case ($urandom_range(4))
			0:       return 16'h0000;
			1:       return thr;
			2:       return thr + 16'd1;
			3:       return 16'hFFFF;
			default: return 16'($urandom);
		endcase
	endfunction

	// A well-formed icon with random content and small counts.
	function automatic void build_icon(int npaths, int max_cont, int max_pts);
		int          p;
		int          c;
		int          q;
		int          ncont;
		int          npts;
		logic [47:0] rgb_f;
		logic [47:0] rgb_s;
		frame_q.delete();
		put_magic(0);
		put16(16'(npaths));
		for (p = 0; p < npaths; p++) begin
			ncont = $urandom_range(max_cont);
			rgb_f = 48'({$urandom, $urandom});
			rgb_s = 48'({$urandom, $urandom});
			put_path_header({pick_alpha(), rgb_f}, {pick_alpha(), rgb_s}, 16'($urandom),
				16'(ncont));
			for (c = 0; c < ncont; c++) begin
				npts = $urandom_range(max_pts);
				put16(16'(npts));
				for (q = 0; q < npts; q++) begin
					put16(16'($urandom));
					put16(16'($urandom));
				end
			end
		end
	endfunction

	// One byte transfer, with random sender gaps ahead of it.
	task automatic send_byte(input logic [7:0] b, input logic fs);
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		data_byte <= b;
		frame_start <= fs;
		do @(posedge clk); while (!in_ready);
	endtask

	// Send frame_q[from .. upto-1]; the frame start goes on byte 0 when asked for.
	task automatic send_span(input int from, input int upto, input bit fs_first);
		int i;
		for (i = from; i < upto && i < frame_q.size(); i++) begin
			send_byte(frame_q[i], fs_first && i == 0);
			sent_bytes++;
		end
	endtask

	// Bytes after the icon has ended; the decoder ignores them.
	task automatic send_noise(input int n);
		int i;
		for (i = 0; i < n; i++) begin
			send_byte(8'($urandom), 1'b0);
			sent_bytes++;
		end
	endtask

	// Hold the sender off until every record due has come out, then let the pipeline empty.
	task automatic wait_settled();
		in_valid <= 1'b0;
		@(posedge clk);
		while (parse_track.due_records.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_threshold(input logic [15:0] v);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	// Mostly whole icons, with bad magics, cut-off frames and trailing junk mixed in.
	task automatic run_random(input int target);
		int first;
		int pick;
		int cut;
		first = sent_bytes;
		while (sent_bytes - first < target) begin
			pick = $urandom_range(99);
			if (pick < 70) begin
				build_icon(($urandom_range(9) == 0) ? 0 : $urandom_range(1, 3), 3, 4);
				send_span(0, frame_q.size(), 1'b1);
				if ($urandom_range(4) == 0)
					send_noise($urandom_range(1, 4));
			end else if (pick < 82) begin
				frame_q.delete();
				put_magic(1);
				send_span(0, 4, 1'b1);
				if ($urandom_range(1) == 0)
					send_noise($urandom_range(1, 4));
			end else begin
				build_icon($urandom_range(1, 3), 3, 4);
				cut = $urandom_range(1, frame_q.size() - 1);
				send_span(0, cut, 1'b1);
			end
		end
	endtask

	initial begin
		parse_track = new();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Without a frame start the first byte after reset is still a magic byte;
		// a zero path count ends the icon at once, and later bytes are ignored.
		frame_q.delete();
		put_magic(0);
		put16(16'h0000);
		send_span(0, frame_q.size(), 1'b0);
		send_noise(2);

		// Magic wrong only in its last byte.
		frame_q.delete();
		put_byte(MAGIC_B0);
		put_byte(MAGIC_B1);
		put_byte(MAGIC_B2);
		put_byte(MAGIC_B3 ^ 8'h80);
		send_span(0, 4, 1'b1);

		// Alphas just above and at the threshold, a negative bevel width, an empty contour,
		// all four point types at coordinate extremes; the last point also ends the icon.
		frame_q.delete();
		put_magic(0);
		put16(16'd1);
		put_path_header({ALPHA_THR_RESET + 16'd1, 48'h0}, {ALPHA_THR_RESET, 48'hFFFF_FFFF_FFFF},
			16'h8001, 16'd2);
		put16(16'd0);
		put16(16'd4);
		put16(16'h7FFE);
		put16(16'h8000);
		put16(16'hFFFF);
		put16(16'h0001);
		put16(16'h8001);
		put16(16'h7FFE);
		put16(16'h0000);
		put16(16'h7FFF);
		send_span(0, frame_q.size(), 1'b1);

		// Largest counts, cut short by the next frame start; the sender also waits
		// mid-frame until all records so far have arrived.
		frame_q.delete();
		put_magic(0);
		put16(16'hFFFF);
		put_path_header(64'hFFFF_FFFF_FFFF_FFFF, 64'h0, 16'h7FFE, 16'hFFFF);
		put16(16'hFFFF);
		put16(16'h0000);
		put16(16'h0000);
		send_span(0, 26, 1'b1);
		wait_settled();
		send_span(26, frame_q.size(), 1'b0);

		// Random traffic under three threshold settings and three idling patterns.
		wait_settled();
		write_threshold(16'h0000);
		send_idle = 33;
		recv_idle = 70;
		run_random(RANDOM_BYTES / 3);

		wait_settled();
		write_threshold(16'hFFFF);
		send_idle = 70;
		recv_idle = 33;
		run_random(RANDOM_BYTES / 3);

		wait_settled();
		write_threshold(16'($urandom));
		send_idle = 0;
		recv_idle = 0;
		run_random(RANDOM_BYTES - 2 * (RANDOM_BYTES / 3));

		wait_settled();
		if (parse_track.errors == 0 && parse_track.due_records.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

>>> filelist.f
sv/vicsd_pkg.sv
sv/vicsd_front.sv
sv/vicsd_fifo.sv
sv/vicsd_back.sv
sv/vector_icon_stream_decoder_unit.sv
verif/vector_icon_stream_decoder_unit_tb.sv
